>>> rtl/core/accel_shake_detector_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the accelerometer shake detector
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ACCEL_SHAKE_DETECTOR_TOP_ASSERT_SVH
`define ACCEL_SHAKE_DETECTOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define ASD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("shake detector assertion failed");

// Next-cycle implication.
`define ASD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("shake detector assertion failed");

`else

`define ASD_ASSERT_NOW(lbl, ante, cons)
`define ASD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> rtl/core/asd_pkg.sv
// ----------------------------------------------------------------------------
// asd_pkg
// Shared widths, register indexes, reset values and types of the shake detector.
// ----------------------------------------------------------------------------
package asd_pkg;

    localparam int DEF_SAMPLE_BITS = 16;
    localparam int DEF_TIME_BITS   = 32;

    localparam int GRAVITY_W  = 15;
    localparam int THRESH_W   = 15;
    localparam int WINDOW_W   = 16;
    localparam int HITS_W     = 5;
    localparam int QUIET_W    = 8;
    localparam int LEVEL_W    = 16;   // gravity + threshold
    localparam int LEVEL_SQ_W = 2 * LEVEL_W;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_GRAVITY  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESH   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HITS     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_QUIET    = 3'd4;

    localparam logic [GRAVITY_W-1:0] RST_GRAVITY = 15'd4096;
    localparam logic [THRESH_W-1:0]  RST_THRESH  = 15'd2048;
    localparam logic [WINDOW_W-1:0]  RST_WINDOW  = 16'd500;
    localparam logic [HITS_W-1:0]    RST_HITS    = 5'd3;
    localparam logic [QUIET_W-1:0]   RST_QUIET   = 8'd10;

    typedef struct packed {
        logic [WINDOW_W-1:0] window_ms;
        logic [HITS_W-1:0]   hits_needed;
        logic [QUIET_W-1:0]  quiet_needed;
    } t_asd_arm_cfg;

    typedef struct packed {
        logic shake_pulse;
        logic is_armed;
    } t_asd_result;

endpackage

>>> rtl/core/asd_hit_detect.sv
// ----------------------------------------------------------------------------
// asd_hit_detect
// Squared magnitude of one sample compared against the squared hit bounds.
// ----------------------------------------------------------------------------
module asd_hit_detect import asd_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic signed [SAMPLE_BITS-1:0] i_accel_x,
    input  logic signed [SAMPLE_BITS-1:0] i_accel_y,
    input  logic signed [SAMPLE_BITS-1:0] i_accel_z,
    input  logic        [LEVEL_SQ_W-1:0]  i_hi_sq,
    input  logic        [LEVEL_SQ_W-1:0]  i_lo_sq,
    input  logic                          i_lo_valid,
    output logic                          o_hit
);

    localparam int SQ_W  = 2 * SAMPLE_BITS;
    localparam int SUM_W = SQ_W + 2;
    localparam int CMP_W = (SUM_W > LEVEL_SQ_W) ? SUM_W : LEVEL_SQ_W;

    logic signed [SAMPLE_BITS-1:0] s_axis [3];
    logic        [SAMPLE_BITS-1:0] s_mag  [3];
    logic        [SQ_W-1:0]        s_sq   [3];
    logic        [SUM_W-1:0]       s_sum;
    logic        [CMP_W-1:0]       s_sum_x;
    logic        [CMP_W-1:0]       s_hi_x;
    logic        [CMP_W-1:0]       s_lo_x;

    assign s_axis[0] = i_accel_x;
    assign s_axis[1] = i_accel_y;
    assign s_axis[2] = i_accel_z;

    // The most negative code negates to itself, which read unsigned is its magnitude.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            s_mag[k] = s_axis[k][SAMPLE_BITS-1] ? SAMPLE_BITS'(-s_axis[k])
                                                : SAMPLE_BITS'(s_axis[k]);
            s_sq[k]  = SQ_W'(s_mag[k]) * SQ_W'(s_mag[k]);
        end
    end

    assign s_sum   = SUM_W'(s_sq[0]) + SUM_W'(s_sq[1]) + SUM_W'(s_sq[2]);
    assign s_sum_x = CMP_W'(s_sum);
    assign s_hi_x  = CMP_W'(i_hi_sq);
    assign s_lo_x  = CMP_W'(i_lo_sq);

    assign o_hit = (s_sum_x >= s_hi_x) || (i_lo_valid && (s_sum_x <= s_lo_x));

endmodule

>>> rtl/core/asd_arm_ctrl.sv
// ----------------------------------------------------------------------------
// asd_arm_ctrl
// Arm state, hit window and quiet counter; one update per processed sample.
// ----------------------------------------------------------------------------
module asd_arm_ctrl import asd_pkg::*; #(
    parameter int TIME_BITS = DEF_TIME_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic                 i_hit,
    input  logic [TIME_BITS-1:0] i_time,
    input  t_asd_arm_cfg         i_cfg,
    output t_asd_result          o_result
);

    localparam int CMP_W = (TIME_BITS > WINDOW_W) ? TIME_BITS : WINDOW_W;

    logic                 r_armed;
    logic [HITS_W-1:0]    r_hit_count;
    logic [QUIET_W-1:0]   r_quiet_count;
    logic [TIME_BITS-1:0] r_window_begin;

    logic                 n_armed;
    logic [HITS_W-1:0]    n_hit_count;
    logic [QUIET_W-1:0]   n_quiet_count;
    logic [TIME_BITS-1:0] n_window_begin;

    logic [TIME_BITS-1:0] s_elapsed;
    logic                 s_expired;
    logic [HITS_W-1:0]    s_hits_inc;
    logic [QUIET_W-1:0]   s_quiet_inc;
    logic                 s_pulse;

    assign s_elapsed = i_time - r_window_begin;
    assign s_expired = CMP_W'(s_elapsed) > CMP_W'(i_cfg.window_ms);

    always_comb begin
        n_armed        = r_armed;
        n_hit_count    = r_hit_count;
        n_quiet_count  = r_quiet_count;
        n_window_begin = r_window_begin;
        s_pulse        = 1'b0;
        s_hits_inc     = '0;
        s_quiet_inc    = r_quiet_count + QUIET_W'(1);
        if (!r_armed) begin
            if (!i_hit) begin
                n_quiet_count = s_quiet_inc;
                if (s_quiet_inc >= i_cfg.quiet_needed) begin
                    n_quiet_count = '0;
                    n_hit_count   = '0;
                    n_armed       = 1'b1;
                end
            end else begin
                n_quiet_count = '0;
            end
        end else begin
            // restart the window once it has run out
            if (s_expired) begin
                n_hit_count    = '0;
                n_window_begin = i_time;
            end
            if (i_hit) begin
                if (n_hit_count == '0) begin
                    n_window_begin = i_time;
                end
                s_hits_inc  = n_hit_count + HITS_W'(1);
                n_hit_count = s_hits_inc;
                if (s_hits_inc >= i_cfg.hits_needed) begin
                    n_hit_count = '0;
                    n_armed     = 1'b0;
                    s_pulse     = 1'b1;
                end
            end
        end
    end

    assign o_result.shake_pulse = s_pulse;
    assign o_result.is_armed    = n_armed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed        <= 1'b1;
            r_hit_count    <= '0;
            r_quiet_count  <= '0;
            r_window_begin <= '0;
        end else if (i_step) begin
            r_armed        <= n_armed;
            r_hit_count    <= n_hit_count;
            r_quiet_count  <= n_quiet_count;
            r_window_begin <= n_window_begin;
        end
    end

endmodule

>>> rtl/core/accel_shake_detector_top.sv
// ----------------------------------------------------------------------------
// accel_shake_detector_top
// Accelerometer shake detector: flags hits by squared magnitude against
// gravity bounds, counts hits in a time window and pulses on a shake.
// ----------------------------------------------------------------------------
//  channel  | valid        | ready        | payload
//  ---------+--------------+--------------+-----------------------------------------
//  config   | i_cfg_valid  | o_cfg_ready  | i_cfg_index, i_cfg_data
//  sample   | i_in_valid   | o_in_ready   | i_accel_x, i_accel_y, i_accel_z, i_time_ms
//  result   | o_out_valid  | i_out_ready  | o_shake_pulse, o_is_armed, o_hit_seen
//
//  One sample per cycle sustained while i_out_ready drains results; o_out_valid rises
//  as the input register feeds squares, compares, arm update and the result register.
//  Squared bounds are registered from the config registers, in the cycle after a write.
//  Synchronous active-low reset restores register defaults and arms the detector.
//  A stalled result holds; the input register still fills behind it.
// ----------------------------------------------------------------------------
`include "accel_shake_detector_top_assert.svh"

module accel_shake_detector_top import asd_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int TIME_BITS   = DEF_TIME_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,

    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_accel_x,
    input  logic signed [SAMPLE_BITS-1:0] i_accel_y,
    input  logic signed [SAMPLE_BITS-1:0] i_accel_z,
    input  logic        [TIME_BITS-1:0]   i_time_ms,

    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_shake_pulse,
    output logic                          o_is_armed,
    output logic                          o_hit_seen
);

    // configuration registers
    logic [GRAVITY_W-1:0]  r_gravity;
    logic [THRESH_W-1:0]   r_thresh;
    logic [WINDOW_W-1:0]   r_window;
    logic [HITS_W-1:0]     r_hits;
    logic [QUIET_W-1:0]    r_quiet;

    logic [LEVEL_SQ_W-1:0] r_hi_sq;
    logic [LEVEL_SQ_W-1:0] r_lo_sq;
    logic                  r_lo_valid;
    logic [LEVEL_W-1:0]    s_hi;
    logic [GRAVITY_W-1:0]  s_lo;
    logic [LEVEL_SQ_W-1:0] n_hi_sq;
    logic [LEVEL_SQ_W-1:0] n_lo_sq;
    logic                  n_lo_valid;

    // input register
    logic                          r_s1_valid;
    logic signed [SAMPLE_BITS-1:0] r_accel_x;
    logic signed [SAMPLE_BITS-1:0] r_accel_y;
    logic signed [SAMPLE_BITS-1:0] r_accel_z;
    logic        [TIME_BITS-1:0]   r_time;

    // result register
    logic r_out_valid;
    logic r_shake_pulse;
    logic r_is_armed;
    logic r_hit_seen;

    logic         s_in_fire;
    logic         s_out_free;
    logic         s_s1_fire;
    logic         s_hit;
    t_asd_arm_cfg s_arm_cfg;
    t_asd_result  s_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity <= RST_GRAVITY;
            r_thresh  <= RST_THRESH;
            r_window  <= RST_WINDOW;
            r_hits    <= RST_HITS;
            r_quiet   <= RST_QUIET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GRAVITY: r_gravity <= i_cfg_data[GRAVITY_W-1:0];
                CFG_THRESH:  r_thresh  <= i_cfg_data[THRESH_W-1:0];
                CFG_WINDOW:  r_window  <= i_cfg_data[WINDOW_W-1:0];
                CFG_HITS:    r_hits    <= i_cfg_data[HITS_W-1:0];
                CFG_QUIET:   r_quiet   <= i_cfg_data[QUIET_W-1:0];
                default: ;
            endcase
        end
    end

    // squared bounds follow the config registers in the next cycle
    assign s_hi       = LEVEL_W'(r_gravity) + LEVEL_W'(r_thresh);
    assign s_lo       = r_gravity - r_thresh;
    assign n_hi_sq    = LEVEL_SQ_W'(s_hi) * LEVEL_SQ_W'(s_hi);
    assign n_lo_sq    = LEVEL_SQ_W'(s_lo) * LEVEL_SQ_W'(s_lo);
    assign n_lo_valid = (r_gravity >= r_thresh);

    always_ff @(posedge i_clk) begin
        r_hi_sq    <= n_hi_sq;
        r_lo_sq    <= n_lo_sq;
        r_lo_valid <= n_lo_valid;
    end

    assign s_out_free = !r_out_valid || i_out_ready;
    assign s_s1_fire  = r_s1_valid && s_out_free;
    assign o_in_ready = !r_s1_valid || s_out_free;
    assign s_in_fire  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s_s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_in_fire) begin
            r_accel_x <= i_accel_x;
            r_accel_y <= i_accel_y;
            r_accel_z <= i_accel_z;
            r_time    <= i_time_ms;
        end
    end

    asd_hit_detect #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_hit_detect (
        .i_accel_x  (r_accel_x),
        .i_accel_y  (r_accel_y),
        .i_accel_z  (r_accel_z),
        .i_hi_sq    (r_hi_sq),
        .i_lo_sq    (r_lo_sq),
        .i_lo_valid (r_lo_valid),
        .o_hit      (s_hit)
    );

    assign s_arm_cfg.window_ms    = r_window;
    assign s_arm_cfg.hits_needed  = r_hits;
    assign s_arm_cfg.quiet_needed = r_quiet;

    asd_arm_ctrl #(
        .TIME_BITS (TIME_BITS)
    ) u_arm_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s_s1_fire),
        .i_hit    (s_hit),
        .i_time   (r_time),
        .i_cfg    (s_arm_cfg),
        .o_result (s_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_s1_fire) begin
            r_shake_pulse <= s_result.shake_pulse;
            r_is_armed    <= s_result.is_armed;
            r_hit_seen    <= s_hit;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_shake_pulse = r_shake_pulse;
    assign o_is_armed    = r_is_armed;
    assign o_hit_seen    = r_hit_seen;

    `ASD_ASSERT_NOW(a_pulse_disarms, o_out_valid && o_shake_pulse, !o_is_armed)
    `ASD_ASSERT_NOW(a_pulse_needs_hit, o_out_valid && o_shake_pulse, o_hit_seen)
    `ASD_ASSERT_NEXT(a_s1_holds, r_s1_valid && !s_out_free, r_s1_valid)

endmodule
